FILE: rtl/core/stream_slot_scheduler_unit_defines.svh
// Assertion macros shared by the scheduler RTL.
`ifndef STREAM_SLOT_SCHEDULER_UNIT_DEFINES_SVH
`define STREAM_SLOT_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet in reset.
`define SSS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sss check failed");

// Next-cycle implication.
`define SSS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sss check failed");

`endif

FILE: rtl/core/sss_pkg.sv
// Types, codes and defaults of the stream slot scheduler.
package sss_pkg;

	localparam int MAX_SLOTS_DEF   = 32;
	localparam int MAX_STREAMS_DEF = 32;

	localparam logic [2:0] FUNC_ADD     = 3'd0;
	localparam logic [2:0] FUNC_DEL     = 3'd1;
	localparam logic [2:0] FUNC_MOD     = 3'd2;
	localparam logic [2:0] FUNC_COMPUTE = 3'd3;
	localparam logic [2:0] FUNC_USAGE   = 3'd4;

	localparam logic [2:0] KIND_SLOT = 3'd0;
	localparam logic [2:0] KIND_END  = 3'd1;
	localparam logic [2:0] KIND_DONE = 3'd2;
	localparam logic [2:0] KIND_DUP  = 3'd3;
	localparam logic [2:0] KIND_FULL = 3'd4;

	localparam logic [1:0] REG_NO_FREE  = 2'd0;
	localparam logic [1:0] REG_ONE_FREE = 2'd1;
	localparam logic [1:0] REG_MISSED   = 2'd2;

	// what the output register is loaded with
	localparam logic [2:0] EM_NONE = 3'd0;
	localparam logic [2:0] EM_RESP = 3'd1;
	localparam logic [2:0] EM_ACK  = 3'd2;
	localparam logic [2:0] EM_BL   = 3'd3;
	localparam logic [2:0] EM_RR   = 3'd4;
	localparam logic [2:0] EM_END  = 3'd5;

	typedef struct packed {
		logic [2:0]  func;
		logic [15:0] node;
		logic [7:0]  stream_ident;
		logic        acks_pending;
		logic        free_slot_choice;
		logic [4:0]  slot_pos;
		logic        slot_used;
	} in_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] slot_node;
		logic [5:0]  data_slot_count;
		logic        free_slot_count;
		logic        last;
	} out_t;

	typedef struct packed {
		logic       load;
		logic       scan_clr;
		logic       scan_step;
		logic       kill;
		logic       sweep_clr;
		logic       sweep_step;
		logic       sweep_fin;
		logic       add_wr;
		logic       purge;
		logic       usage;
		logic       cmp_init;
		logic       bl_skip;
		logic       push_bl;
		logic [2:0] emit;
		logic [2:0] kind;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       scan_end;
		logic       found;
		logic       free;
		logic       sweep_end;
		logic       acks;
		logic       bl_left;
		logic       lt_max;
		logic       lt_budget;
		logic       p_zero;
		logic       ord_empty;
		logic       out_free;
	} sts_t;

endpackage

FILE: rtl/core/sss_ctrl.sv
// Sequencer of the stream slot scheduler.
module sss_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sss_pkg::sts_t sts,
	output sss_pkg::cmd_t cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_DISP  = 4'd1;
	localparam logic [3:0] ST_FIND  = 4'd2;
	localparam logic [3:0] ST_SWD   = 4'd3;
	localparam logic [3:0] ST_RESP  = 4'd4;
	localparam logic [3:0] ST_SWC   = 4'd5;
	localparam logic [3:0] ST_CINIT = 4'd6;
	localparam logic [3:0] ST_ACK   = 4'd7;
	localparam logic [3:0] ST_BL    = 4'd8;
	localparam logic [3:0] ST_RR    = 4'd9;
	localparam logic [3:0] ST_END   = 4'd10;

	logic [3:0] state_q, state_d;
	logic       add_mode_q, add_mode_d;
	logic       mod_q, mod_d;
	logic [2:0] kind_q, kind_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		add_mode_d = add_mode_q;
		mod_d      = mod_q;
		kind_d     = kind_q;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DISP;
				end
			end
			ST_DISP: begin
				unique case (sts.func) inside
					sss_pkg::FUNC_ADD, sss_pkg::FUNC_DEL, sss_pkg::FUNC_MOD: begin
						cmd.scan_clr = 1'b1;
						add_mode_d   = (sts.func == sss_pkg::FUNC_ADD);
						mod_d        = (sts.func == sss_pkg::FUNC_MOD);
						state_d      = ST_FIND;
					end
					sss_pkg::FUNC_COMPUTE: begin
						cmd.purge     = 1'b1;
						cmd.sweep_clr = 1'b1;
						state_d       = ST_SWC;
					end
					sss_pkg::FUNC_USAGE: begin
						cmd.usage = 1'b1;
						kind_d    = sss_pkg::KIND_DONE;
						state_d   = ST_RESP;
					end
					default: begin
						kind_d  = sss_pkg::KIND_DONE;
						state_d = ST_RESP;
					end
				endcase
			end
			ST_FIND: begin
				if (!sts.scan_end) begin
					cmd.scan_step = 1'b1;
				end else if (!add_mode_q) begin
					if (sts.found) begin
						cmd.kill      = 1'b1;
						cmd.sweep_clr = 1'b1;
						state_d       = ST_SWD;
					end else if (mod_q) begin
						cmd.scan_clr = 1'b1;
						add_mode_d   = 1'b1;
					end else begin
						kind_d  = sss_pkg::KIND_DONE;
						state_d = ST_RESP;
					end
				end else begin
					if (sts.found) begin
						kind_d = sss_pkg::KIND_DUP;
					end else if (sts.free) begin
						cmd.add_wr = 1'b1;
						kind_d     = sss_pkg::KIND_DONE;
					end else begin
						kind_d = sss_pkg::KIND_FULL;
					end
					state_d = ST_RESP;
				end
			end
			ST_SWD: begin
				if (!sts.sweep_end) begin
					cmd.sweep_step = 1'b1;
				end else begin
					cmd.sweep_fin = 1'b1;
					if (mod_q) begin
						cmd.scan_clr = 1'b1;
						add_mode_d   = 1'b1;
						state_d      = ST_FIND;
					end else begin
						kind_d  = sss_pkg::KIND_DONE;
						state_d = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (sts.out_free) begin
					cmd.emit = sss_pkg::EM_RESP;
					cmd.kind = kind_q;
					state_d  = ST_IDLE;
				end
			end
			ST_SWC: begin
				if (!sts.sweep_end) begin
					cmd.sweep_step = 1'b1;
				end else begin
					cmd.sweep_fin = 1'b1;
					state_d       = ST_CINIT;
				end
			end
			ST_CINIT: begin
				cmd.cmp_init = 1'b1;
				state_d      = ST_ACK;
			end
			ST_ACK: begin
				if (!sts.acks) begin
					state_d = ST_BL;
				end else if (sts.out_free) begin
					cmd.emit = sss_pkg::EM_ACK;
					state_d  = ST_BL;
				end
			end
			ST_BL: begin
				if (!sts.bl_left) begin
					state_d = ST_RR;
				end else if (!sts.lt_max) begin
					cmd.bl_skip = 1'b1;
				end else if (sts.out_free) begin
					cmd.emit = sss_pkg::EM_BL;
				end
			end
			ST_RR: begin
				if (sts.p_zero && (sts.ord_empty || !sts.lt_budget)) begin
					state_d = ST_END;
				end else if (sts.lt_budget) begin
					if (sts.out_free) begin
						cmd.emit = sss_pkg::EM_RR;
					end
				end else begin
					cmd.push_bl = 1'b1;
				end
			end
			ST_END: begin
				if (sts.out_free) begin
					cmd.emit = sss_pkg::EM_END;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			add_mode_q <= 1'b0;
			mod_q      <= 1'b0;
			kind_q     <= sss_pkg::KIND_DONE;
		end else begin
			state_q    <= state_d;
			add_mode_q <= add_mode_d;
			mod_q      <= mod_d;
			kind_q     <= kind_d;
		end
	end

endmodule

FILE: rtl/core/sss_dp.sv
// Stream table, order list, backlog, slot owners and output register.
module sss_dp #(
	parameter int MAX_SLOTS   = sss_pkg::MAX_SLOTS_DEF,
	parameter int MAX_STREAMS = sss_pkg::MAX_STREAMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  sss_pkg::in_t  in_data,
	input  logic          cfg_valid,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data,
	output sss_pkg::out_t out_data,
	output logic          out_valid,
	input  logic          out_ready,
	input  sss_pkg::cmd_t cmd,
	output sss_pkg::sts_t sts
);

	localparam int SW = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CW = $clog2(MAX_STREAMS + 1);
	localparam int LW = $clog2(MAX_SLOTS);
	localparam int AW = $clog2(MAX_SLOTS + 1);
	localparam int NS = (MAX_SLOTS > MAX_STREAMS) ? MAX_SLOTS : MAX_STREAMS;
	localparam int NW = $clog2(NS + 1);

	sss_pkg::in_t  req_q;
	sss_pkg::out_t out_q;
	logic          out_valid_q;
	logic [5:0]    nof_q, one_q;
	logic [7:0]    lim_q;

	logic [MAX_STREAMS-1:0] valid_q;
	logic [15:0]            node_q   [MAX_STREAMS];
	logic [7:0]             stream_q [MAX_STREAMS];
	logic [7:0]             missed_q [MAX_STREAMS];
	logic [SW-1:0]          order_q  [MAX_STREAMS];
	logic [CW-1:0]          ord_cnt_q;
	logic [SW-1:0]          bl_q     [MAX_SLOTS];
	logic [AW-1:0]          bl_cnt_q;
	logic [SW-1:0]          owner_q  [MAX_SLOTS];
	logic [MAX_SLOTS-1:0]   own_ok_q;
	logic [AW-1:0]          slot_total_q;

	logic [CW-1:0] scan_q;
	logic          found_q, free_q;
	logic [SW-1:0] found_idx_q, free_idx_q;
	logic [NW-1:0] sw_i_q;
	logic [CW-1:0] w_ord_q;
	logic [AW-1:0] w_bl_q;
	logic [AW-1:0] assigned_q, budget_q, old_bl_q, b_q;
	logic [CW-1:0] p_q;

	logic [SW-1:0] sk, ox, bx, e_b, e_r, eu;
	logic [LW-1:0] oi, ue;
	logic          match, in_ord, in_bl, in_own, keep_o, keep_b, u_ok;
	logic [5:0]    bsel;
	logic [AW-1:0] budget;
	logic [CW-1:0] p_inc, p_next;
	logic [MAX_STREAMS-1:0] over;

	// scan of one table entry
	assign sk    = scan_q[SW-1:0];
	assign match = valid_q[sk] && (node_q[sk] == req_q.node)
		&& (stream_q[sk] == req_q.stream_ident);

	// compaction sweep
	assign in_ord = sw_i_q < NW'(ord_cnt_q);
	assign in_bl  = sw_i_q < NW'(bl_cnt_q);
	assign in_own = sw_i_q < NW'(MAX_SLOTS);
	assign ox     = order_q[sw_i_q[SW-1:0]];
	assign bx     = bl_q[sw_i_q[LW-1:0]];
	assign oi     = sw_i_q[LW-1:0];
	assign keep_o = in_ord && valid_q[ox];
	assign keep_b = in_bl && valid_q[bx];

	// schedule
	assign bsel   = req_q.free_slot_choice ? one_q : nof_q;
	assign budget = (bsel > 6'(MAX_SLOTS)) ? AW'(MAX_SLOTS) : AW'(bsel);
	assign e_b    = bl_q[b_q[LW-1:0]];
	assign e_r    = order_q[p_q[SW-1:0]];
	assign p_inc  = p_q + 1'b1;
	assign p_next = (p_inc == ord_cnt_q) ? '0 : p_inc;

	// usage report
	assign ue   = LW'(req_q.slot_pos);
	assign eu   = owner_q[ue];
	assign u_ok = (req_q.slot_pos != 5'd0)
		&& (6'(req_q.slot_pos) < 6'(slot_total_q))
		&& (6'(req_q.slot_pos) < 6'(MAX_SLOTS))
		&& own_ok_q[ue] && valid_q[eu];

	always_comb begin
		for (int k = 0; k < MAX_STREAMS; k++) begin
			over[k] = missed_q[k] > lim_q;
		end
	end

	always_comb begin
		sts.func      = req_q.func;
		sts.scan_end  = (scan_q == CW'(MAX_STREAMS));
		sts.found     = found_q;
		sts.free      = free_q;
		sts.sweep_end = (sw_i_q == NW'(NS));
		sts.acks      = req_q.acks_pending;
		sts.bl_left   = b_q < old_bl_q;
		sts.lt_max    = assigned_q < AW'(MAX_SLOTS);
		sts.lt_budget = assigned_q < budget_q;
		sts.p_zero    = (p_q == '0);
		sts.ord_empty = (ord_cnt_q == '0);
		sts.out_free  = !out_valid_q || out_ready;
	end

	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	// control counters and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nof_q        <= 6'd32;
			one_q        <= 6'd31;
			lim_q        <= 8'd3;
			valid_q      <= '0;
			ord_cnt_q    <= '0;
			bl_cnt_q     <= '0;
			slot_total_q <= '0;
			own_ok_q     <= '0;
			out_valid_q  <= 1'b0;
			scan_q       <= '0;
			found_q      <= 1'b0;
			free_q       <= 1'b0;
			sw_i_q       <= '0;
			w_ord_q      <= '0;
			w_bl_q       <= '0;
			assigned_q   <= '0;
			budget_q     <= '0;
			old_bl_q     <= '0;
			b_q          <= '0;
			p_q          <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					sss_pkg::REG_NO_FREE:  nof_q <= cfg_data[5:0];
					sss_pkg::REG_ONE_FREE: one_q <= cfg_data[5:0];
					sss_pkg::REG_MISSED:   lim_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.scan_clr) begin
				scan_q  <= '0;
				found_q <= 1'b0;
				free_q  <= 1'b0;
			end else if (cmd.scan_step) begin
				scan_q <= scan_q + 1'b1;
				if (match) begin
					found_q <= 1'b1;
				end
				if (!valid_q[sk] && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (cmd.kill) begin
				valid_q[found_idx_q] <= 1'b0;
			end
			if (cmd.purge) begin
				valid_q <= valid_q & ~over;
			end
			if (cmd.add_wr) begin
				valid_q[free_idx_q] <= 1'b1;
				ord_cnt_q           <= ord_cnt_q + 1'b1;
			end
			if (cmd.sweep_clr) begin
				sw_i_q  <= '0;
				w_ord_q <= '0;
				w_bl_q  <= '0;
			end else if (cmd.sweep_step) begin
				sw_i_q <= sw_i_q + 1'b1;
				if (keep_o) begin
					w_ord_q <= w_ord_q + 1'b1;
				end
				if (keep_b) begin
					w_bl_q <= w_bl_q + 1'b1;
				end
				if (in_own && own_ok_q[oi] && !valid_q[owner_q[oi]]) begin
					own_ok_q[oi] <= 1'b0;
				end
			end
			if (cmd.sweep_fin) begin
				ord_cnt_q <= w_ord_q;
				bl_cnt_q  <= w_bl_q;
			end
			if (cmd.cmp_init) begin
				assigned_q <= '0;
				budget_q   <= budget;
				old_bl_q   <= bl_cnt_q;
				bl_cnt_q   <= '0;
				b_q        <= '0;
				p_q        <= '0;
			end
			if (cmd.bl_skip) begin
				b_q <= b_q + 1'b1;
			end
			if (cmd.push_bl) begin
				p_q <= p_next;
				if (bl_cnt_q < AW'(MAX_SLOTS)) begin
					bl_cnt_q <= bl_cnt_q + 1'b1;
				end
			end
			// a new item is only loaded once the register is free
			out_valid_q <= (cmd.emit != sss_pkg::EM_NONE) || (out_valid_q && !out_ready);
			case (cmd.emit)
				sss_pkg::EM_ACK: begin
					own_ok_q[0]  <= 1'b0;
					assigned_q   <= AW'(1);
				end
				sss_pkg::EM_BL: begin
					own_ok_q[assigned_q[LW-1:0]] <= 1'b1;
					assigned_q  <= assigned_q + 1'b1;
					b_q         <= b_q + 1'b1;
				end
				sss_pkg::EM_RR: begin
					own_ok_q[assigned_q[LW-1:0]] <= 1'b1;
					assigned_q  <= assigned_q + 1'b1;
					p_q         <= p_next;
				end
				sss_pkg::EM_END: begin
					slot_total_q <= assigned_q;
				end
				default: ;
			endcase
		end
	end

	// payload storage, no reset
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= in_data;
		end
		if (cmd.scan_step) begin
			if (match) begin
				found_idx_q <= sk;
			end
			if (!valid_q[sk] && !free_q) begin
				free_idx_q <= sk;
			end
		end
		if (cmd.add_wr) begin
			node_q[free_idx_q]                <= req_q.node;
			stream_q[free_idx_q]              <= req_q.stream_ident;
			missed_q[free_idx_q]              <= 8'd0;
			order_q[ord_cnt_q[SW-1:0]]        <= free_idx_q;
		end
		if (cmd.usage && u_ok) begin
			if (req_q.slot_used) begin
				missed_q[eu] <= 8'd0;
			end else if (missed_q[eu] != 8'hFF) begin
				missed_q[eu] <= missed_q[eu] + 8'd1;
			end
		end
		if (cmd.sweep_step) begin
			if (keep_o) begin
				order_q[w_ord_q[SW-1:0]] <= ox;
			end
			if (keep_b) begin
				bl_q[w_bl_q[LW-1:0]] <= bx;
			end
		end
		if (cmd.push_bl && (bl_cnt_q < AW'(MAX_SLOTS))) begin
			bl_q[bl_cnt_q[LW-1:0]] <= e_r;
		end
		case (cmd.emit)
			sss_pkg::EM_RESP: begin
				out_q.kind            <= cmd.kind;
				out_q.slot_node       <= (cmd.kind == sss_pkg::KIND_DUP) ? req_q.node : 16'd0;
				out_q.data_slot_count <= 6'd0;
				out_q.free_slot_count <= 1'b0;
				out_q.last            <= 1'b1;
			end
			sss_pkg::EM_ACK: begin
				out_q <= '{sss_pkg::KIND_SLOT, 16'd0, 6'd0, 1'b0, 1'b0};
			end
			sss_pkg::EM_BL: begin
				owner_q[assigned_q[LW-1:0]] <= e_b;
				out_q <= '{sss_pkg::KIND_SLOT, node_q[e_b], 6'd0, 1'b0, 1'b0};
			end
			sss_pkg::EM_RR: begin
				owner_q[assigned_q[LW-1:0]] <= e_r;
				out_q <= '{sss_pkg::KIND_SLOT, node_q[e_r], 6'd0, 1'b0, 1'b0};
			end
			sss_pkg::EM_END: begin
				out_q <= '{sss_pkg::KIND_END, 16'd0, 6'(assigned_q),
					req_q.free_slot_choice, 1'b1};
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/stream_slot_scheduler_unit.sv
// Top level of the stream slot scheduler: sequencer plus datapath.
//
// Keeps up to MAX_STREAMS streams in insertion order and builds slot schedules of up
// to MAX_SLOTS data slots. One item is worked on at a time; in_ready is high only
// while the block is idle. Every table search and every compaction walks the
// stored entries one per cycle. An add searches the table and writes the stream into
// a free entry; a delete of a present stream clears its entry and compacts the
// lists; a modify deletes a present stream and then adds it; a usage report or an
// unknown func is answered without a search. A compute first purges stale streams
// with a compaction sweep, then emits one slot per cycle while out_ready does not
// stall (ack slot if pending, backlog, round-robin), queues leftover streams to the
// backlog, and ends with the schedule end item. Results come through one output
// register, so the sequencer moves on as soon as the previous result is taken.
// Config writes are always accepted (cfg_ready is tied high) and must only come
// while the block is idle. No clearing pass is needed after reset: only the valid
// bits, the config registers, the counters and flags and the slot owner marks
// reset; the stored payload does not.
module stream_slot_scheduler_unit #(
	parameter int MAX_SLOTS   = sss_pkg::MAX_SLOTS_DEF,
	parameter int MAX_STREAMS = sss_pkg::MAX_STREAMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  sss_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output sss_pkg::out_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [1:0]    cfg_index,
	input  logic [7:0]    cfg_data
);

`include "stream_slot_scheduler_unit_defines.svh"

	sss_pkg::cmd_t cmd;
	sss_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	sss_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sss_dp #(
		.MAX_SLOTS   (MAX_SLOTS),
		.MAX_STREAMS (MAX_STREAMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// an accepted item makes the block busy in the next cycle
	`SSS_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// a schedule end item closes the item
	`SSS_ASSERT_IMP(a_end_is_last, out_valid && (out_data.kind == sss_pkg::KIND_END), out_data.last)
	// slot items never close the item
	`SSS_ASSERT_IMP(a_slot_not_last, out_valid && (out_data.kind == sss_pkg::KIND_SLOT), !out_data.last)
	// a schedule never holds more slots than MAX_SLOTS
	`SSS_ASSERT_IMP(a_slot_count, out_valid, out_data.data_slot_count <= 6'(MAX_SLOTS))

endmodule
